@@ sv/ssed_pkg.sv @@
package ssed_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int RESP_W     = 24;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int CFG_W  = 11;
	localparam int LVL_W  = 4;
	localparam int IDX_W  = 2;

	localparam int S_DATA_W = 3 * RESP_W;
	localparam int M_DATA_W = RESP_W + ROW_W + COL_W + LVL_W;

	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_SCALE_LEVEL  = 2'd2;

	localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(MAX_WIDTH);
	localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(MAX_HEIGHT);
	localparam logic [LVL_W-1:0] LEVEL_RST  = LVL_W'(1);
	localparam logic [CFG_W-1:0] SIZE_MIN   = CFG_W'(3);

	localparam logic POL_MAX = 1'b0;
	localparam logic POL_MIN = 1'b1;

	// one pixel: three scales, finer scale in the lowest bits
	typedef struct packed {
		logic signed [RESP_W-1:0] upper;
		logic signed [RESP_W-1:0] middle;
		logic signed [RESP_W-1:0] lower;
	} pix_t;

	// one line store word: row r-2 above row r-1
	typedef struct packed {
		pix_t line1;
		pix_t line0;
	} line_pair_t;

endpackage

@@ sv/scale_space_extremum_detector.sv @@
// path: an input beat passes the stage 1 register, the stage 2 window and the output register
// throughput: one input beat per cycle while the result stream does not stall, at most one result beat per input beat
// stages: line store read, window shift with line store write, 26-way compare
// reset: counters, window, stage valids and configuration registers return to their reset values
// the line store is not cleared; its contents are undefined until written
module scale_space_extremum_detector (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream; tdata from bit 0: resp_lower, resp_middle, resp_upper
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ssed_pkg::S_DATA_W-1:0]   s_tdata,
	// result stream; tdata from bit 0: magnitude, row_index, col_index, level_label
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ssed_pkg::M_DATA_W-1:0]   m_tdata,
	// tuser: polarity (0 maximum, 1 minimum)
	output logic                            m_tuser,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [ssed_pkg::IDX_W-1:0]      cfg_index,
	input  logic [ssed_pkg::CFG_W-1:0]      cfg_wdata
);
	import ssed_pkg::*;

	// configuration registers
	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic [LVL_W-1:0] scale_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RST;
			frame_height_q <= HEIGHT_RST;
			scale_level_q  <= LEVEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
				REG_SCALE_LEVEL:  scale_level_q  <= cfg_wdata[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	// effective frame size, clamped to the supported range
	logic [CFG_W-1:0] w_eff;
	logic [CFG_W-1:0] h_eff;

	always_comb begin
		if (frame_width_q < SIZE_MIN)
			w_eff = SIZE_MIN;
		else if (frame_width_q > CFG_W'(MAX_WIDTH))
			w_eff = CFG_W'(MAX_WIDTH);
		else
			w_eff = frame_width_q;
		if (frame_height_q < SIZE_MIN)
			h_eff = SIZE_MIN;
		else if (frame_height_q > CFG_W'(MAX_HEIGHT))
			h_eff = CFG_W'(MAX_HEIGHT);
		else
			h_eff = frame_height_q;
	end

	// pipeline handshake: each stage moves on when the next one has room
	logic s1_v_s1;
	logic s2_v_s2;
	logic out_v_q;
	logic hit;
	logic out_free;
	logic s2_go;
	logic s2_free;
	logic s1_go;
	logic in_beat;

	assign out_free = !out_v_q || m_tready;
	// an item with no result leaves stage 2 without needing the output register
	assign s2_go    = s2_v_s2 && (!hit || out_free);
	assign s2_free  = !s2_v_s2 || s2_go;
	assign s1_go    = s1_v_s1 && s2_free;
	assign s_tready = !s1_v_s1 || s1_go;
	assign in_beat  = s_tvalid && s_tready;

	// raster position counters
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_nxt;
	logic [ROW_W-1:0] row_nxt;
	logic [CFG_W-1:0] col_inc;
	logic [CFG_W-1:0] row_inc;
	logic [CFG_W-1:0] row_tmp;

	always_comb begin
		col_inc = CFG_W'(col_q) + CFG_W'(1);
		row_inc = CFG_W'(row_q) + CFG_W'(1);
		row_tmp = CFG_W'(row_q);
		col_nxt = col_inc[COL_W-1:0];
		if (col_inc >= w_eff) begin
			col_nxt = '0;
			// wrap to the first row after the last one
			row_tmp = (row_inc >= h_eff) ? '0 : row_inc;
		end
		// a height shrunk in mid-frame wraps at once
		if (row_tmp >= h_eff)
			row_tmp = '0;
		row_nxt = row_tmp[ROW_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_beat) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	// stage 1: input register and line store read
	pix_t             cur_s1;
	line_pair_t       rd_s1;
	logic [COL_W-1:0] addr_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_s1;
	logic             act_s1;

	// both previous lines of a column share one word, read and rewritten once per beat
	line_pair_t line_mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (in_beat)
			rd_s1 <= line_mem[col_q];
		// the following beat reads another column, so no bypass is needed
		if (s1_go)
			line_mem[addr_s1] <= '{line1: rd_s1.line0, line0: cur_s1};
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			cur_s1  <= pix_t'(s_tdata);
			addr_s1 <= col_q;
			// centre sits one row up and one column left
			row_s1  <= row_q - ROW_W'(1);
			col_s1  <= col_q - COL_W'(1);
			// no centre on the border or while the window spans a line start
			act_s1  <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_v_s1 <= 1'b0;
		else if (s_tready)
			s1_v_s1 <= s_tvalid;
	end

	// stage 2: 3x3 window of pixel triples, row 0 oldest line, column 2 newest
	pix_t             win_q [3][3];
	logic [ROW_W-1:0] row_s2;
	logic [COL_W-1:0] col_s2;
	logic             act_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int y = 0; y < 3; y++)
				for (int x = 0; x < 3; x++)
					win_q[y][x] <= '0;
		end else if (s1_go) begin
			for (int y = 0; y < 3; y++)
				for (int x = 0; x < 2; x++)
					win_q[y][x] <= win_q[y][x+1];
			win_q[0][2] <= rd_s1.line1;
			win_q[1][2] <= rd_s1.line0;
			win_q[2][2] <= cur_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			row_s2 <= row_s1;
			col_s2 <= col_s1;
			act_s2 <= act_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s2_v_s2 <= 1'b0;
		else if (s2_free)
			s2_v_s2 <= s1_go;
	end

	// 26-neighbour test against the middle-plane centre
	logic signed [RESP_W-1:0] ctr;
	logic                     is_max;
	logic                     is_min;
	logic [RESP_W-1:0]        mag;

	assign ctr = win_q[1][1].middle;

	always_comb begin
		is_max = 1'b1;
		is_min = 1'b1;
		for (int y = 0; y < 3; y++) begin
			for (int x = 0; x < 3; x++) begin
				if (!(ctr > win_q[y][x].lower))
					is_max = 1'b0;
				if (!(ctr < win_q[y][x].lower))
					is_min = 1'b0;
				if (!(ctr > win_q[y][x].upper))
					is_max = 1'b0;
				if (!(ctr < win_q[y][x].upper))
					is_min = 1'b0;
				if (!(y == 1 && x == 1)) begin
					if (!(ctr > win_q[y][x].middle))
						is_max = 1'b0;
					if (!(ctr < win_q[y][x].middle))
						is_min = 1'b0;
				end
			end
		end
	end

	assign hit = act_s2 && (is_max || is_min);
	// the most negative response maps to 2^23, which still fits unsigned
	assign mag = ctr[RESP_W-1] ? RESP_W'(-ctr) : RESP_W'(ctr);

	// output register
	logic [M_DATA_W-1:0] out_data_q;
	logic                out_pol_q;

	always_ff @(posedge clk) begin
		if (s2_go && hit) begin
			out_data_q <= {scale_level_q, col_s2, row_s2, mag};
			// maximum test takes precedence
			out_pol_q  <= is_max ? POL_MAX : POL_MIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (s2_go && hit)
			out_v_q <= 1'b1;
		else if (m_tready)
			out_v_q <= 1'b0;
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_pol_q;

endmodule
